// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
        else $error("assertion lbl failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion lbl failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion lbl failed");

`endif

// ----- sv/lbp_pkg.sv -----
// shared types, constants and helpers of the lsb-first bit packer
package lbp_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam int OP_W       = 2;
    localparam int FW_W       = 6;
    localparam int DATA_W     = 32;
    localparam int BADDR_W    = 8;
    localparam int BITS_W     = 12;
    localparam int BYTES_W    = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int SPAN_BYTES = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 1'd1;
    localparam logic [BYTES_W-1:0]   SIZE_RESET      = BYTES_W'(BUFFER_BYTES);

    typedef enum logic [OP_W-1:0] {
        OP_FIELD   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_FETCH   = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    // what the back end has to do with one item
    typedef enum logic [1:0] {
        K_NONE,
        K_PACK,
        K_UNPACK
    } kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PK_RD,
        BK_PK_WR,
        BK_UP,
        BK_DONE
    } bk_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   base;
        logic [2:0]          off;
        logic [FW_W-1:0]     width;
        logic [DATA_W-1:0]   data;
        logic [BITS_W-1:0]   bits_used;
        logic [BYTES_W-1:0]  bytes_used;
        logic [BITS_W-1:0]   bits_left;
        logic                overflow;
    } cmd_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic logic [DATA_W-1:0] mask_of(input logic [FW_W-1:0] w);
        logic [DATA_W:0] t;
        t = ({{DATA_W{1'b0}}, 1'b1} << w) - {{DATA_W{1'b0}}, 1'b1};
        return t[DATA_W-1:0];
    endfunction

endpackage

// ----- sv/lbp_ifs.sv -----
// valid/ready channel interfaces for items and results
interface lbp_in_if;
    import lbp_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [FW_W-1:0]     field_width;
    logic [DATA_W-1:0]   data_in;
    logic [BADDR_W-1:0]  byte_address;

    modport source (output valid, op, field_width, data_in, byte_address, input ready);
    modport sink (input valid, op, field_width, data_in, byte_address, output ready);
endinterface

interface lbp_out_if;
    import lbp_pkg::*;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   data_out;
    logic [BITS_W-1:0]   bits_used;
    logic [BYTES_W-1:0]  bytes_used;
    logic [BITS_W-1:0]   bits_left;
    logic                overflow;

    modport source (output valid, data_out, bits_used, bytes_used, bits_left, overflow,
                    input ready);
    modport sink (input valid, data_out, bits_used, bytes_used, bits_left, overflow,
                  output ready);
endinterface

// ----- sv/lbp_ram.sv -----
// generic single-write, single-read ram with registered read data
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- sv/lbp_front.sv -----
// front end: takes items, checks bounds, tracks the bit position, queues commands
module lbp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    lbp_in_if.sink                      in_ch,
    input  logic                        read_mode,
    input  logic [lbp_pkg::BYTES_W-1:0] buffer_size,
    input  logic                        q_full,
    output logic                        push,
    output lbp_pkg::cmd_t               cmd
);
    import lbp_pkg::*;

    logic [BYTES_W-1:0] ptr_reg, ptr_next;
    logic [2:0]         off_reg, off_next;
    logic [BYTES_W-1:0] size_bytes;
    logic [BITS_W-1:0]  size_bits;
    logic [BITS_W-1:0]  pos;
    logic [BITS_W:0]    end_pos;
    logic [BYTES_W-1:0] touched;
    logic [BITS_W-1:0]  used;
    logic               width_ok;
    logic               addr_ovf;

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        size_bytes = (buffer_size > SIZE_RESET) ? SIZE_RESET : buffer_size;
        size_bits  = {size_bytes, 3'b000};
        pos        = {ptr_reg, off_reg};
        end_pos    = {1'b0, pos} + {{(BITS_W+1-FW_W){1'b0}}, in_ch.field_width};
        touched    = ptr_reg + {{(BYTES_W-1){1'b0}}, (off_reg != 3'd0)};
        width_ok   = in_ch.field_width inside {[6'd1:6'd32]};
        addr_ovf   = {1'b0, in_ch.byte_address} >= size_bytes;
    end

    // classify the item and work out the position it leaves behind
    always_comb
    begin
        ptr_next       = ptr_reg;
        off_next       = off_reg;
        cmd            = '0;
        cmd.kind       = K_NONE;
        cmd.base       = ptr_reg[ADDR_W-1:0];
        cmd.off        = off_reg;
        cmd.width      = in_ch.field_width;
        cmd.data       = in_ch.data_in;
        case (op_t'(in_ch.op))
            OP_FIELD:
            begin
                if (width_ok)
                begin
                    if (end_pos > {1'b0, size_bits})
                    begin
                        cmd.overflow = 1'b1;
                    end
                    else
                    begin
                        cmd.kind = read_mode ? K_UNPACK : K_PACK;
                        ptr_next = end_pos[BITS_W-1:3];
                        off_next = end_pos[2:0];
                    end
                end
            end
            OP_LOAD:
            begin
                cmd.base  = in_ch.byte_address[ADDR_W-1:0];
                cmd.off   = 3'd0;
                cmd.width = FW_W'(8);
                if (addr_ovf)
                begin
                    cmd.overflow = 1'b1;
                end
                else
                begin
                    cmd.kind = K_PACK;
                end
            end
            OP_FETCH:
            begin
                cmd.base  = in_ch.byte_address[ADDR_W-1:0];
                cmd.off   = 3'd0;
                cmd.width = FW_W'(8);
                if (addr_ovf)
                begin
                    cmd.overflow = 1'b1;
                end
                else if (read_mode || ({1'b0, in_ch.byte_address} < touched))
                begin
                    cmd.kind = K_UNPACK;
                end
            end
            OP_RESTART:
            begin
                ptr_next = '0;
                off_next = '0;
            end
            default:
            begin
                cmd.kind = K_NONE;
            end
        endcase
        used           = {ptr_next, off_next};
        cmd.bits_used  = used;
        cmd.bytes_used = ptr_next + {{(BYTES_W-1){1'b0}}, (off_next != 3'd0)};
        cmd.bits_left  = (size_bits > used) ? (size_bits - used) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            off_reg <= '0;
        end
        else if (push)
        begin
            ptr_reg <= ptr_next;
            off_reg <= off_next;
        end
    end
endmodule

// ----- sv/lbp_queue.sv -----
// short command queue between front and back end
module lbp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lbp_pkg::cmd_t push_data,
    input  logic          pop,
    output lbp_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);
    import lbp_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ----- sv/lbp_back.sv -----
// back end: byte-serial sequencer over the store ram, builds the result
module lbp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  lbp_pkg::cmd_t    q_data,
    output logic             pop,
    output lbp_pkg::ram_req_t ram_req,
    input  logic [7:0]       ram_rdata,
    lbp_out_if.source        out_ch
);
    import lbp_pkg::*;

    localparam int ACC_W = SPAN_BYTES * 8;

    bk_state_t          state_reg, state_next;
    cmd_t               cmd_reg;
    logic [2:0]         cnt_reg, cnt_next;
    logic [2:0]         iss_reg, iss_next;
    logic               iss_done_reg, iss_done_next;
    logic               rv_reg, rv_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               out_valid_reg;
    logic [DATA_W-1:0]  data_out_reg;
    logic [BITS_W-1:0]  bits_used_reg;
    logic [BYTES_W-1:0] bytes_used_reg;
    logic [BITS_W-1:0]  bits_left_reg;
    logic               overflow_reg;

    logic [6:0]         span;
    logic [2:0]         nlast;
    logic [ACC_W-1:0]   shifted;
    logic [ACC_W-1:0]   acc_shr;
    logic [DATA_W-1:0]  result;
    logic               out_free;
    logic               load_out;

    always_comb
    begin
        span     = {4'd0, cmd_reg.off} + {1'b0, cmd_reg.width} - 7'd1;
        nlast    = span[5:3];
        shifted  = {{(ACC_W-DATA_W){1'b0}}, cmd_reg.data & mask_of(cmd_reg.width)}
                   << cmd_reg.off;
        acc_shr  = acc_reg >> cmd_reg.off;
        result   = (cmd_reg.kind == K_UNPACK)
                   ? (acc_shr[DATA_W-1:0] & mask_of(cmd_reg.width)) : '0;
        out_free = !out_valid_reg || out_ch.ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_data.kind)
                        K_PACK:   state_next = (q_data.off != 3'd0) ? BK_PK_RD : BK_PK_WR;
                        K_UNPACK: state_next = BK_UP;
                        default:  state_next = BK_DONE;
                    endcase
                end
            end
            BK_PK_RD: state_next = BK_PK_WR;
            BK_PK_WR:
            begin
                if (cnt_reg == nlast)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_UP:
            begin
                if (rv_reg && cnt_reg == nlast)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop           = 1'b0;
        ram_req       = '0;
        cnt_next      = cnt_reg;
        iss_next      = iss_reg;
        iss_done_next = iss_done_reg;
        rv_next       = 1'b0;
        acc_next      = acc_reg;
        load_out      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop           = !q_empty;
                cnt_next      = '0;
                iss_next      = '0;
                iss_done_next = 1'b0;
                acc_next      = '0;
            end
            BK_PK_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = cmd_reg.base;
            end
            BK_PK_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cmd_reg.base + ADDR_W'(cnt_reg);
                ram_req.wdata = shifted[cnt_reg*8 +: 8];
                // first byte at a nonzero offset merges with what is there
                if (cnt_reg == 3'd0 && cmd_reg.off != 3'd0)
                begin
                    ram_req.wdata = shifted[7:0] | ram_rdata;
                end
                cnt_next = cnt_reg + 3'd1;
            end
            BK_UP:
            begin
                ram_req.re    = !iss_done_reg;
                ram_req.raddr = cmd_reg.base + ADDR_W'(iss_reg);
                rv_next       = !iss_done_reg;
                if (!iss_done_reg)
                begin
                    if (iss_reg == nlast)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_next = iss_reg + 3'd1;
                    end
                end
                if (rv_reg)
                begin
                    acc_next[cnt_reg*8 +: 8] = ram_rdata;
                    cnt_next                 = cnt_reg + 3'd1;
                end
            end
            BK_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_data;
        end
        cnt_reg      <= cnt_next;
        iss_reg      <= iss_next;
        iss_done_reg <= iss_done_next;
        acc_reg      <= acc_next;
        if (load_out)
        begin
            data_out_reg   <= result;
            bits_used_reg  <= cmd_reg.bits_used;
            bytes_used_reg <= cmd_reg.bytes_used;
            bits_left_reg  <= cmd_reg.bits_left;
            overflow_reg   <= cmd_reg.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.data_out   = data_out_reg;
    assign out_ch.bits_used  = bits_used_reg;
    assign out_ch.bytes_used = bytes_used_reg;
    assign out_ch.bits_left  = bits_left_reg;
    assign out_ch.overflow   = overflow_reg;
endmodule

// ----- sv/lsb_first_bit_packer.sv -----
// a result passes from the input through the command queue and then the back end's byte sequence
// to unpack a field the back end reads each store byte it covers, to pack it writes each one
// (reading a partly filled first byte first for the read-modify-write); a load writes one byte,
// a fetch that reads the store reads one, every other op none; the single byte-wide store port
// serialises these; input takes a transfer each cycle until the four-entry command queue fills
// reset clears position, mode (pack), size (256 bytes) and queue; store contents undefined
module lsb_first_bit_packer (
    input  logic                           clk,
    input  logic                           rst_n,
    lbp_in_if.sink                         in_ch,
    lbp_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lbp_pkg::*;

    // configuration registers
    logic               read_mode_reg;
    logic [BYTES_W-1:0] buffer_size_reg;

    // front to queue
    logic     push;
    cmd_t     push_cmd;
    logic     q_full;

    // queue to back
    logic     pop;
    cmd_t     pop_cmd;
    logic     q_empty;

    // back to store
    ram_req_t   ram_req;
    logic [7:0] ram_rdata;

    // the user must write registers only while the block is idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_mode_reg   <= 1'b0;
            buffer_size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_READ_MODE:   read_mode_reg   <= cfg_data[0];
                CFG_BUFFER_SIZE: buffer_size_reg <= cfg_data[BYTES_W-1:0];
                default:         read_mode_reg   <= read_mode_reg;
            endcase
        end
    end

    // front end owns the bit position and resolves overflow and status up front
    lbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .read_mode   (read_mode_reg),
        .buffer_size (buffer_size_reg),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    lbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back end walks the store one byte per cycle and holds the result register
    lbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (pop_cmd),
        .pop       (pop),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .out_ch    (out_ch)
    );

    // byte store
    lbp_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );
endmodule

// ----- sv/lbp_checker.sv -----
// port-level checks on the result channel of the bit packer, bound to the top level
`include "assert_macros.svh"

module lbp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [lbp_pkg::DATA_W-1:0]  data_out,
    input logic [lbp_pkg::BITS_W-1:0]  bits_used,
    input logic [lbp_pkg::BYTES_W-1:0] bytes_used,
    input logic [lbp_pkg::BITS_W-1:0]  bits_left,
    input logic                        overflow
);
    import lbp_pkg::*;

    logic [BYTES_W-1:0] bytes_calc;
    logic [BITS_W:0]    bits_total;

    assign bytes_calc = bits_used[BITS_W-1:3]
                        + {{(BYTES_W-1){1'b0}}, (bits_used[2:0] != 3'd0)};
    assign bits_total = {1'b0, bits_used} + {1'b0, bits_left};

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(data_out))

    // byte count follows bit position
    `ASSERT_IMPL(a_bytes_match, clk, rst_n, out_valid, bytes_used == bytes_calc)

    // a refused access returns no data
    `ASSERT_IMPL(a_ovf_no_data, clk, rst_n, out_valid && overflow, data_out == '0)

    // position and room never exceed the largest buffer
    `ASSERT_IMPL(a_bits_bound, clk, rst_n, out_valid, bits_total <= (BITS_W+1)'(BUFFER_BYTES * 8))
endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .data_out   (out_ch.data_out),
    .bits_used  (out_ch.bits_used),
    .bytes_used (out_ch.bytes_used),
    .bits_left  (out_ch.bits_left),
    .overflow   (out_ch.overflow)
);

// ----- tb/tb_top.sv -----
// self-checking testbench for the lsb-first bit packer: directed table, store preload, random phases
module tb_top;
    import lbp_pkg::*;

    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 130;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 40;

    // one input transfer as the predictor sees it
    typedef struct packed {
        op_t                op;
        logic [FW_W-1:0]    width;
        logic [DATA_W-1:0]  data;
        logic [BADDR_W-1:0] addr;
    } item_t;

    // one output transfer
    typedef struct packed {
        logic [DATA_W-1:0]  data_out;
        logic [BITS_W-1:0]  bits_used;
        logic [BYTES_W-1:0] bytes_used;
        logic [BITS_W-1:0]  bits_left;
        logic               overflow;
    } result_t;

    // a row of the directed table: either a register write or an item
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        item_t                 it;
        bit                    typed;
        result_t               res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lbp_in_if  in_ch();
    lbp_out_if out_ch();

    lsb_first_bit_packer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the block: store, position and registers
    logic [7:0]            shadow_store [BUFFER_BYTES];
    int unsigned           cur_byte;
    int unsigned           cur_bit;
    logic                  shadow_read_mode;
    logic [CFG_DATA_W-1:0] shadow_size;

    result_t   pending_results [$];
    stim_row_t directed_rows [$];

    // typed expectation for the item currently on the input channel
    bit      next_typed;
    result_t next_typed_res;

    int mismatches;
    int n_in;
    int n_results;
    int n_packed;
    int n_unpacked;
    int n_refused;
    int n_phases;
    int stall_cycles;
    int calm_left [2];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // gap length before the next transfer; side 0 is the sender, 1 the receiver
    function automatic int idle_len(input int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        // now and then a stretch with no idling at all
        if (r < 3)
        begin
            calm_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // applies one item to the shadow state and returns the result it produces
    function automatic result_t advance_packer(input item_t it);
        result_t     r;
        int unsigned size_b;
        int unsigned pos;
        int unsigned w;
        int unsigned room;
        int unsigned n;
        int unsigned got;
        int unsigned touched;
        int unsigned used;
        logic [63:0] acc;
        logic [63:0] v;
        logic [7:0]  chunk;
        r = '0;
        size_b = (shadow_size > BUFFER_BYTES) ? BUFFER_BYTES : shadow_size;
        case (it.op)
            OP_FIELD:
            begin
                // widths of zero or above 32 leave everything as it is
                if (it.width >= 1 && it.width <= 32)
                begin
                    pos = cur_byte * 8 + cur_bit;
                    if (pos + it.width > size_b * 8)
                    begin
                        r.overflow = 1'b1;
                        n_refused++;
                    end
                    else
                    begin
                        w   = it.width;
                        v   = {32'd0, it.data};
                        acc = '0;
                        got = 0;
                        while (w > 0)
                        begin
                            room = 8 - cur_bit;
                            n    = (w < room) ? w : room;
                            if (shadow_read_mode)
                                acc |= 64'((shadow_store[cur_byte] >> cur_bit)
                                           & 8'((1 << n) - 1)) << got;
                            else
                            begin
                                chunk = 8'((v & 64'((1 << n) - 1)) << cur_bit);
                                // a part starting a byte replaces it, a later part merges in
                                if (cur_bit == 0)
                                    shadow_store[cur_byte] = chunk;
                                else
                                    shadow_store[cur_byte] = shadow_store[cur_byte] | chunk;
                            end
                            v       = v >> n;
                            got     = got + n;
                            w       = w - n;
                            cur_bit = cur_bit + n;
                            if (cur_bit >= 8)
                            begin
                                cur_byte++;
                                cur_bit = 0;
                            end
                        end
                        if (shadow_read_mode)
                        begin
                            r.data_out = acc[31:0];
                            n_unpacked++;
                        end
                        else
                            n_packed++;
                    end
                end
            end
            OP_LOAD:
            begin
                if (it.addr >= size_b)
                begin
                    r.overflow = 1'b1;
                    n_refused++;
                end
                else
                    shadow_store[it.addr] = it.data[7:0];
            end
            OP_FETCH:
            begin
                if (it.addr >= size_b)
                begin
                    r.overflow = 1'b1;
                    n_refused++;
                end
                else
                begin
                    // in pack mode bytes past the write point read as zero
                    touched = cur_byte + ((cur_bit != 0) ? 1 : 0);
                    if (shadow_read_mode || it.addr < touched)
                        r.data_out = {24'd0, shadow_store[it.addr]};
                end
            end
            default:
            begin
                cur_byte = 0;
                cur_bit  = 0;
            end
        endcase
        used         = cur_byte * 8 + cur_bit;
        r.bits_used  = BITS_W'(used);
        r.bytes_used = BYTES_W'(cur_byte + ((cur_bit != 0) ? 1 : 0));
        r.bits_left  = BITS_W'((size_b * 8 > used) ? size_b * 8 - used : 0);
        return r;
    endfunction

    // random item: mostly well-formed field streams, with loads, fetches, restarts and noise
    function automatic item_t random_item();
        item_t       it;
        int          r;
        int unsigned size_b;
        size_b  = (shadow_size > BUFFER_BYTES) ? BUFFER_BYTES : shadow_size;
        it.data = $urandom;
        if ($urandom_range(0, 19) == 0)
            it.data = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'h0;
        it.width = FW_W'($urandom_range(1, 32));
        if (size_b > 0 && $urandom_range(0, 4) != 0)
            it.addr = BADDR_W'($urandom_range(0, size_b - 1));
        else
            it.addr = BADDR_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            it.op = OP_FIELD;
            if (r < 7)
                it.width = 6'd32;
            else if (r < 12)
                it.width = 6'd1;
        end
        else if (r < 73)
        begin
            // out-of-range widths, zero and above 32
            it.op    = OP_FIELD;
            it.width = ($urandom_range(0, 2) == 0) ? 6'd0 : FW_W'($urandom_range(33, 63));
        end
        else if (r < 82)
            it.op = OP_LOAD;
        else if (r < 94)
            it.op = OP_FETCH;
        else
            it.op = OP_RESTART;
        return it;
    endfunction

    function automatic void add_item(input op_t op, input int w, input logic [31:0] d,
                                     input int a);
        stim_row_t row;
        row        = '{default: '0};
        row.it.op    = op;
        row.it.width = FW_W'(w);
        row.it.data  = d;
        row.it.addr  = BADDR_W'(a);
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input op_t op, input int w, input logic [31:0] d,
                                        input int a, input logic [31:0] dout, input int used,
                                        input int bytes, input int left, input bit ovf);
        stim_row_t row;
        row              = '{default: '0};
        row.it.op        = op;
        row.it.width     = FW_W'(w);
        row.it.data      = d;
        row.it.addr      = BADDR_W'(a);
        row.typed        = 1'b1;
        row.res.data_out   = dout;
        row.res.bits_used  = BITS_W'(used);
        row.res.bytes_used = BYTES_W'(bytes);
        row.res.bits_left  = BITS_W'(left);
        row.res.overflow   = ovf;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        stim_row_t row;
        row         = '{default: '0};
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = CFG_DATA_W'(val);
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                     n_results, what, got, want);
    endtask

    // drive one item at the falling edge and hold it until the transfer
    task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
        int gap;
        gap = idle_len(0);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= it.op;
        in_ch.field_width  <= it.width;
        in_ch.data_in      <= it.data;
        in_ch.byte_address <= it.addr;
        next_typed     = typed;
        next_typed_res = typed_res;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and let every outstanding result come back, with a bound
    task automatic wait_drain();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write, only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_READ_MODE)
            shadow_read_mode = val[0];
        else
            shadow_size = val;
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        item_t                 it;
        logic                  mode;
        logic [CFG_DATA_W-1:0] size_val;
        // every input at a known level from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_READ_MODE;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_FIELD;
        in_ch.field_width  = '0;
        in_ch.data_in      = '0;
        in_ch.byte_address = '0;
        next_typed         = 1'b0;
        next_typed_res     = '0;
        shadow_read_mode   = 1'b0;
        shadow_size        = SIZE_RESET;
        cur_byte           = 0;
        cur_bit            = 0;
        mismatches         = 0;
        n_in               = 0;
        n_results          = 0;
        n_packed           = 0;
        n_unpacked         = 0;
        n_refused          = 0;
        n_phases           = 0;
        calm_left[0]       = 0;
        calm_left[1]       = 0;

        // directed part, pack mode straight out of reset
        add_checked(OP_RESTART, 0, 32'h0, 0, 32'h0, 0, 0, 2048, 1'b0);
        add_checked(OP_FETCH, 0, 32'h0, 0, 32'h0, 0, 0, 2048, 1'b0);
        // invalid widths change nothing
        add_checked(OP_FIELD, 0, 32'hFFFF_FFFF, 0, 32'h0, 0, 0, 2048, 1'b0);
        add_checked(OP_FIELD, 63, 32'hFFFF_FFFF, 0, 32'h0, 0, 0, 2048, 1'b0);
        add_checked(OP_FIELD, 33, 32'hFFFF_FFFF, 0, 32'h0, 0, 0, 2048, 1'b0);
        // narrowest and widest fields, the second one straddling five bytes
        add_checked(OP_FIELD, 1, 32'h0000_0001, 0, 32'h0, 1, 1, 2047, 1'b0);
        add_checked(OP_FIELD, 32, 32'hFFFF_FFFF, 0, 32'h0, 33, 5, 2015, 1'b0);
        add_item(OP_FIELD, 7, 32'hFFFF_FF5A, 0);
        add_item(OP_FETCH, 0, 32'h0, 0);
        // fetch past the write point reads zero
        add_item(OP_FETCH, 0, 32'h0, 255);
        add_item(OP_LOAD, 0, 32'hFFFF_FFA5, 255);
        add_item(OP_FETCH, 0, 32'h0, 4);
        // empty buffer: every access is refused
        add_reg(CFG_BUFFER_SIZE, 0);
        add_checked(OP_FIELD, 1, 32'h1, 0, 32'h0, 40, 5, 0, 1'b1);
        add_checked(OP_LOAD, 0, 32'h1, 0, 32'h0, 40, 5, 0, 1'b1);
        add_checked(OP_FETCH, 0, 32'h0, 0, 32'h0, 40, 5, 0, 1'b1);
        // size above the store acts as the full store
        add_reg(CFG_BUFFER_SIZE, 511);
        add_reg(CFG_READ_MODE, 1);
        add_item(OP_RESTART, 0, 32'h0, 0);
        add_item(OP_FIELD, 32, 32'h0, 0);
        add_item(OP_FIELD, 8, 32'h0, 0);
        add_item(OP_FETCH, 0, 32'h0, 255);
        // position exactly at the end, then size shrunk below the position
        add_reg(CFG_BUFFER_SIZE, 5);
        add_checked(OP_FIELD, 1, 32'h0, 0, 32'h0, 40, 5, 0, 1'b1);
        add_reg(CFG_BUFFER_SIZE, 4);
        add_item(OP_FETCH, 0, 32'h0, 3);
        add_item(OP_FIELD, 32, 32'h0, 0);
        add_item(OP_RESTART, 0, 32'h0, 0);
        add_reg(CFG_READ_MODE, 0);
        add_reg(CFG_BUFFER_SIZE, BUFFER_BYTES);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg)
            begin
                wait_drain();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
        end

        // fill the whole store once so no later access can touch an unwritten byte
        for (int a = 0; a < BUFFER_BYTES; a++)
        begin
            it.op    = OP_LOAD;
            it.width = FW_W'($urandom_range(0, 63));
            it.data  = $urandom;
            it.addr  = BADDR_W'(a);
            send_item(it, 1'b0, '0);
        end

        // random phases, each with its own mode and size
        for (int p = 0; p < PHASES; p++)
        begin
            mode = p[0];
            case (p)
                0, 1:       size_val = CFG_DATA_W'(BUFFER_BYTES);
                2:          size_val = '0;
                3:          size_val = CFG_DATA_W'(1);
                4:          size_val = '1;
                5:          size_val = CFG_DATA_W'(2);
                6:          size_val = CFG_DATA_W'($urandom_range(257, 510));
                PHASES - 1: size_val = CFG_DATA_W'(BUFFER_BYTES);
                default:    size_val = CFG_DATA_W'($urandom_range(1, 256));
            endcase
            wait_drain();
            write_reg(CFG_READ_MODE, CFG_DATA_W'(mode));
            write_reg(CFG_BUFFER_SIZE, size_val);
            n_phases++;
            // usually start a fresh stream, sometimes keep the position across the mode change
            if ($urandom_range(0, 3) != 0)
            begin
                it       = random_item();
                it.op    = OP_RESTART;
                send_item(it, 1'b0, '0);
            end
            repeat (PHASE_ITEMS)
                send_item(random_item(), 1'b0, '0);
        end

        wait_drain();
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        $display("covered %0d input transfers and %0d checked results over %0d random phases",
                 n_in, n_results, n_phases);
        $display("fields packed %0d, fields unpacked %0d, accesses refused %0d, mismatches %0d",
                 n_packed, n_unpacked, n_refused, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // receiver: ready high for a short run, then a random stall
    initial
    begin
        int hold;
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(1, 6);
            gap  = idle_len(1);
            out_ch.ready <= 1'b1;
            repeat (hold) @(negedge clk);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    // checker: results against the oldest expectation, then predict accepted items
    always @(posedge clk)
    begin
        item_t   it;
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing expected", out_ch.data_out, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.data_out !== want.data_out)
                        report_mismatch("data_out", out_ch.data_out, want.data_out);
                    if (out_ch.bits_used !== want.bits_used)
                        report_mismatch("bits_used", 32'(out_ch.bits_used),
                                        32'(want.bits_used));
                    if (out_ch.bytes_used !== want.bytes_used)
                        report_mismatch("bytes_used", 32'(out_ch.bytes_used),
                                        32'(want.bytes_used));
                    if (out_ch.bits_left !== want.bits_left)
                        report_mismatch("bits_left", 32'(out_ch.bits_left),
                                        32'(want.bits_left));
                    if (out_ch.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(out_ch.overflow),
                                        32'(want.overflow));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                n_in++;
                it.op    = op_t'(in_ch.op);
                it.width = in_ch.field_width;
                it.data  = in_ch.data_in;
                it.addr  = in_ch.byte_address;
                // the shadow state advances even where the table gives the answer
                pred = advance_packer(it);
                if (next_typed)
                    pending_results.push_back(next_typed_res);
                else
                    pending_results.push_back(pred);
            end
        end
    end

    // watchdog: ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     stall_cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial stall_cycles = 0;

endmodule
